@@ src/sdmpt_pkg.sv @@
// Package with the beat types, register indexes and microstep tables of the position tracker.
`default_nettype none

package sdmpt_pkg;

  // Widths fixed by the pin interface and the register map.
  localparam int unsigned CFG_DATA_W = 31;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned WAKE_W     = 20;
  localparam int unsigned OUT_POS_W  = 32;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_START_POSITION = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_POSITION   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT_DIR     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NO_ENDSTOPS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WAKE_DELAY     = 3'd4;

  // Register reset values.
  localparam logic [CFG_DATA_W-1:0] MAX_POSITION_RST = 31'd3200000;
  localparam logic [WAKE_W-1:0]     WAKE_DELAY_RST   = 20'd1000;

  // Microstep select codes (MS2:MS1).
  localparam logic [1:0] MS_FULL      = 2'd0;
  localparam logic [1:0] MS_HALF      = 2'd1;
  localparam logic [1:0] MS_QUARTER   = 2'd2;
  localparam logic [1:0] MS_SIXTEENTH = 2'd3;

  // One input beat: a sample of the driver pins.
  typedef struct packed {
    logic step_pin;
    logic dir_pin;
    logic enable_n;
    logic reset_n;
    logic sleep_pin;
    logic ms1_pin;
    logic ms2_pin;
  } in_item_t;

  // One result beat.
  typedef struct packed {
    logic signed [OUT_POS_W-1:0] position;
    logic                        at_min;
    logic                        at_max;
    logic                        step_ignored;
    logic                        asleep;
  } out_item_t;

  // One configuration write.
  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  // Step size in sixteenth steps for a microstep code.
  function automatic logic [4:0] step_size(input logic [1:0] code);
    logic [4:0] sz;
    case (code)
      MS_FULL:      sz = 5'd16;
      MS_HALF:      sz = 5'd8;
      MS_QUARTER:   sz = 5'd4;
      MS_SIXTEENTH: sz = 5'd1;
      default:      sz = 5'd16;
    endcase
    return sz;
  endfunction

  // Position bits below the step size, cleared on a microstep change.
  function automatic logic [3:0] align_mask(input logic [1:0] code);
    logic [3:0] m;
    case (code)
      MS_FULL:      m = 4'hF;
      MS_HALF:      m = 4'h7;
      MS_QUARTER:   m = 4'h3;
      MS_SIXTEENTH: m = 4'h0;
      default:      m = 4'hF;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

@@ src/step_dir_microstep_position_tracker.sv @@
// Top level: input register, tracker update logic and result buffer.
// A beat goes from the input register through the update logic into the result buffer.
// Throughput: one sample per cycle while the buffer has room, set by the update loop.
// The two-entry result buffer keeps samples flowing while one result waits to be taken.
// Reset (rst_n low, synchronous) clears the channels, loads position 0 and the register
// defaults, and clears the flags, sleep state and wake countdown.
`default_nettype none

module step_dir_microstep_position_tracker
  import sdmpt_pkg::*;
#(
  parameter int unsigned POSITION_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_item_t                  out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic      in_valid_r;
  in_item_t  in_item_r;
  logic      buf_full;
  logic      advance;
  out_item_t result;
  cfg_wr_t   cfg;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_wdata;

  // The registered beat moves on whenever the result buffer has room.
  assign advance  = in_valid_r & ~buf_full;
  assign in_stall = in_valid_r & buf_full;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_item_r <= in_data;
    end
  end

  sdmpt_core #(
    .POSITION_BITS(POSITION_BITS)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .item_fire(advance),
    .item     (in_item_r),
    .result   (result)
  );

  sdmpt_out_buf u_out_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (advance),
    .push_item(result),
    .out_stall(out_stall),
    .out_valid(out_valid),
    .out_data (out_data),
    .full     (buf_full)
  );

endmodule

`default_nettype wire

@@ src/sdmpt_core.sv @@
// Tracker state, configuration registers and the per-sample update logic.
`default_nettype none

module sdmpt_core
  import sdmpt_pkg::*;
#(
  parameter int unsigned POSITION_BITS = 32
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire cfg_wr_t   cfg,
  input  wire logic      item_fire,
  input  wire in_item_t  item,
  output out_item_t      result
);

  localparam int unsigned PW = POSITION_BITS;
  // Compare width wide enough for both the position and the 31-bit limit.
  localparam int unsigned LW = (PW > CFG_DATA_W) ? PW : CFG_DATA_W + 1;

  // Configuration registers.
  logic [CFG_DATA_W-1:0] max_position_r;
  logic                  invert_dir_r;
  logic                  no_endstops_r;
  logic [WAKE_W-1:0]     wake_delay_r;

  // Tracker state.
  logic [PW-1:0]     pos_r, pos_nxt;
  logic              min_r, min_nxt;
  logic              max_r, max_nxt;
  logic [1:0]        mode_r, mode_nxt;
  logic              prev_step_r;
  logic              prev_sleep_r;
  logic              sleeping_r, sleeping_nxt;
  logic [WAKE_W-1:0] wake_count_r, wake_count_nxt;
  logic              wake_pending_r, wake_pending_nxt;

  logic [LW-1:0] max_ext, pmax_ext, lim_ext;
  logic [PW-1:0] limit;
  logic [PW-1:0] pos_aligned, pos_moved, pos_ld;
  logic [PW-1:0] ld_pos;
  logic          ld_min, ld_max;
  logic [1:0]    code;
  logic          rise, dir, ignored;

  // Upper limit: max_position saturated to the largest positive position.
  always_comb begin
    max_ext  = LW'(max_position_r);
    pmax_ext = LW'({1'b0, {(PW-1){1'b1}}});
    lim_ext  = (max_ext > pmax_ext) ? pmax_ext : max_ext;
    limit    = lim_ext[PW-1:0];
  end

  // Endstop check applied to a start position write.
  always_comb begin
    pos_ld = PW'(cfg.data);
    ld_pos = pos_ld;
    ld_min = 1'b0;
    ld_max = 1'b0;
    if (pos_ld[PW-1]) begin
      ld_pos = '0;
      ld_min = 1'b1;
      ld_max = max_r;
    end else if (pos_ld > limit) begin
      ld_pos = limit;
      ld_min = min_r;
      ld_max = 1'b1;
    end
  end

  // Sample update: wake countdown, sleep level, microstep code, then step edge.
  always_comb begin
    wake_count_nxt   = wake_count_r;
    wake_pending_nxt = wake_pending_r;
    sleeping_nxt     = sleeping_r;
    if (wake_pending_r) begin
      if (wake_count_r != '0) begin
        wake_count_nxt = wake_count_r - WAKE_W'(1);
      end
      if (wake_count_nxt == '0) begin
        wake_pending_nxt = 1'b0;
        sleeping_nxt     = 1'b0;
      end
    end
    if (item.sleep_pin) begin
      sleeping_nxt     = 1'b1;
      wake_pending_nxt = 1'b0;
      wake_count_nxt   = '0;
    end else if (prev_sleep_r) begin
      if (wake_delay_r == '0) begin
        sleeping_nxt     = 1'b0;
        wake_pending_nxt = 1'b0;
        wake_count_nxt   = '0;
      end else begin
        wake_count_nxt   = wake_delay_r;
        wake_pending_nxt = 1'b1;
      end
    end

    // A new microstep code realigns the position to the new step size.
    code        = {item.ms2_pin, item.ms1_pin};
    mode_nxt    = code;
    pos_aligned = pos_r;
    if (code != mode_r) begin
      pos_aligned = pos_r & ~PW'(align_mask(code));
    end

    rise      = item.step_pin & ~prev_step_r;
    dir       = item.dir_pin ^ invert_dir_r;
    ignored   = 1'b0;
    pos_moved = dir ? pos_aligned - PW'(step_size(code))
                    : pos_aligned + PW'(step_size(code));
    pos_nxt   = pos_aligned;
    min_nxt   = min_r;
    max_nxt   = max_r;
    if (rise) begin
      if (item.enable_n || sleeping_nxt || !item.reset_n) begin
        ignored = 1'b1;
      end else begin
        pos_nxt = pos_moved;
        if (!no_endstops_r) begin
          if (pos_moved[PW-1]) begin
            pos_nxt = '0;
            min_nxt = 1'b1;
          end else if (pos_moved > limit) begin
            pos_nxt = limit;
            max_nxt = 1'b1;
          end else begin
            min_nxt = 1'b0;
            max_nxt = 1'b0;
          end
        end
      end
    end

    result.position     = OUT_POS_W'(signed'(pos_nxt));
    result.at_min       = min_nxt;
    result.at_max       = max_nxt;
    result.step_ignored = ignored;
    result.asleep       = sleeping_nxt;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_position_r <= MAX_POSITION_RST;
      invert_dir_r   <= 1'b0;
      no_endstops_r  <= 1'b0;
      wake_delay_r   <= WAKE_DELAY_RST;
    end else if (cfg.we) begin
      case (cfg.index)
        CFG_MAX_POSITION: max_position_r <= cfg.data;
        CFG_INVERT_DIR:   invert_dir_r   <= cfg.data[0];
        CFG_NO_ENDSTOPS:  no_endstops_r  <= cfg.data[0];
        CFG_WAKE_DELAY:   wake_delay_r   <= cfg.data[WAKE_W-1:0];
        default: ;
      endcase
    end
  end

  // State registers; a start position write loads and checks the position.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r          <= '0;
      min_r          <= 1'b0;
      max_r          <= 1'b0;
      mode_r         <= MS_FULL;
      prev_step_r    <= 1'b0;
      prev_sleep_r   <= 1'b0;
      sleeping_r     <= 1'b0;
      wake_count_r   <= '0;
      wake_pending_r <= 1'b0;
    end else if (cfg.we && cfg.index == CFG_START_POSITION) begin
      pos_r <= ld_pos;
      min_r <= ld_min;
      max_r <= ld_max;
    end else if (item_fire) begin
      pos_r          <= pos_nxt;
      min_r          <= min_nxt;
      max_r          <= max_nxt;
      mode_r         <= mode_nxt;
      prev_step_r    <= item.step_pin;
      prev_sleep_r   <= item.sleep_pin;
      sleeping_r     <= sleeping_nxt;
      wake_count_r   <= wake_count_nxt;
      wake_pending_r <= wake_pending_nxt;
    end
  end

endmodule

`default_nettype wire

@@ src/sdmpt_out_buf.sv @@
// Two-entry result buffer that decouples the result channel from the update logic.
`default_nettype none

module sdmpt_out_buf
  import sdmpt_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire out_item_t push_item,
  input  wire logic      out_stall,
  output logic           out_valid,
  output out_item_t      out_data,
  output logic           full
);

  logic [1:0] count_r;
  out_item_t  head_r;
  out_item_t  tail_r;
  logic       pop;

  assign out_valid = (count_r != 2'd0);
  assign out_data  = head_r;
  assign full      = (count_r == 2'd2);
  assign pop       = out_valid & ~out_stall;

  // Occupancy count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
    end else if (push && !pop) begin
      count_r <= count_r + 2'd1;
    end else if (pop && !push) begin
      count_r <= count_r - 2'd1;
    end
  end

  // Entry data: the head is always the oldest beat.
  always_ff @(posedge clk) begin
    case (count_r)
      2'd0: begin
        if (push) head_r <= push_item;
      end
      2'd1: begin
        if (push && pop) begin
          head_r <= push_item;
        end else if (push) begin
          tail_r <= push_item;
        end
      end
      2'd2: begin
        if (pop) head_r <= tail_r;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

@@ src/sdmpt_checker.sv @@
// Port-level checker for the position tracker and its bind to the top level.
`default_nettype none

module sdmpt_checker
  import sdmpt_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_data
);

  // A stalled result beat holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // The input side only stalls when results are backed up.
  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no result pending");

  // A stall on the input side starts only after the result side stalled.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(out_valid && out_stall))
    else $error("input stall without a result stall before it");

  // One drained result frees the input side on the next cycle.
  a_stall_release: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall && !out_stall |=> !in_stall)
    else $error("input stall held after a result beat was taken");

endmodule

bind step_dir_microstep_position_tracker sdmpt_checker u_sdmpt_checker (.*);

`default_nettype wire
